### hdl/kls_pkg.sv
package kls_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int OUT_COUNT_W     = 16;

    // Byte codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Byte roles
    localparam logic [2:0] ROLE_SKIP   = 3'd0;
    localparam logic [2:0] ROLE_GROUP  = 3'd1;
    localparam logic [2:0] ROLE_KEY    = 3'd2;
    localparam logic [2:0] ROLE_LOCALE = 3'd3;
    localparam logic [2:0] ROLE_VALUE  = 3'd4;
    localparam logic [2:0] ROLE_DELIM  = 3'd5;
    localparam logic [2:0] ROLE_EOL    = 3'd6;

    // Line events
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_GROUP  = 2'd1;
    localparam logic [1:0] EV_ASSIGN = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_GROUP      = 2'd1;
    localparam logic [1:0] ERR_LOCALE     = 2'd2;
    localparam logic [1:0] ERR_NOT_ASSIGN = 2'd3;

    typedef enum logic [9:0] {
        PH_START      = 10'b00_0000_0001,
        PH_SKIP       = 10'b00_0000_0010,
        PH_GROUP      = 10'b00_0000_0100,
        PH_GROUP_END  = 10'b00_0000_1000,
        PH_KEY        = 10'b00_0001_0000,
        PH_LOCALE     = 10'b00_0010_0000,
        PH_LOCALE_END = 10'b00_0100_0000,
        PH_VALUE      = 10'b00_1000_0000,
        PH_VALUE_LOC  = 10'b01_0000_0000,
        PH_HALT       = 10'b10_0000_0000
    } phase_t;

    // Result of one parser step, handed from the step logic to the top level
    typedef struct packed {
        phase_t     phase_next;
        logic       nonempty_next;
        logic       line_inc;
        logic       item_inc;
        logic [2:0] role;
        logic [1:0] line_event;
        logic       has_locale;
        logic [1:0] error_code;
    } step_t;

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_key_char(input logic [7:0] b);
        return is_alnum(b) || b == CH_DASH;
    endfunction

    function automatic logic is_locale_char(input logic [7:0] b);
        return is_alnum(b) || b == CH_AT || b == CH_DOT || b == CH_UNDER;
    endfunction

endpackage

### hdl/kls_req_if.sv
interface kls_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### hdl/kls_res_if.sv
interface kls_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic [1:0]  line_event;
    logic        has_locale;
    logic [1:0]  error_code;
    logic [15:0] line_number;
    logic [15:0] item_index;
    logic        file_done;

    modport source (
        output valid, output byte_role, output line_event, output has_locale,
        output error_code, output line_number, output item_index, output file_done,
        input ready
    );
    modport sink (
        input valid, input byte_role, input line_event, input has_locale,
        input error_code, input line_number, input item_index, input file_done,
        output ready
    );
endinterface

### hdl/kls_step.sv
module kls_step (
    input  kls_pkg::phase_t phase,
    input  logic            field_nonempty,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output kls_pkg::step_t  step
);
    import kls_pkg::*;

    logic nl;

    assign nl = (data_byte == CH_NL);

    always_comb
    begin
        step               = '0;
        step.phase_next    = phase;
        step.nonempty_next = field_nonempty;
        step.role          = ROLE_SKIP;
        step.line_event    = EV_NONE;
        step.error_code    = ERR_NONE;

        if (phase != PH_HALT)
        begin
            unique case (phase)
                PH_START:
                begin
                    if (nl)
                        step.role = ROLE_EOL;
                    else if (data_byte == CH_HASH)
                        step.phase_next = PH_SKIP;
                    else if (data_byte == CH_LBRK)
                    begin
                        step.role       = ROLE_DELIM;
                        step.phase_next = PH_GROUP;
                    end
                    else if (is_key_char(data_byte))
                    begin
                        step.role       = ROLE_KEY;
                        step.phase_next = PH_KEY;
                    end
                    else
                        step.error_code = ERR_NOT_ASSIGN;
                end
                PH_SKIP:
                begin
                    step.role = nl ? ROLE_EOL : ROLE_SKIP;
                end
                PH_GROUP:
                begin
                    if (nl)
                        step.error_code = ERR_GROUP;
                    else if (data_byte == CH_RBRK)
                    begin
                        step.role       = ROLE_DELIM;
                        step.phase_next = PH_GROUP_END;
                    end
                    else
                        step.role = ROLE_GROUP;
                end
                PH_GROUP_END:
                begin
                    if (nl)
                    begin
                        step.role       = ROLE_EOL;
                        step.line_event = EV_GROUP;
                    end
                    else
                        step.error_code = ERR_GROUP;
                end
                PH_KEY:
                begin
                    if (is_key_char(data_byte))
                        step.role = ROLE_KEY;
                    else if (data_byte == CH_LBRK)
                    begin
                        step.role          = ROLE_DELIM;
                        step.nonempty_next = 1'b0;
                        step.phase_next    = PH_LOCALE;
                    end
                    else if (data_byte == CH_EQ)
                    begin
                        step.role       = ROLE_DELIM;
                        step.phase_next = PH_VALUE;
                    end
                    else
                        step.error_code = ERR_NOT_ASSIGN;
                end
                PH_LOCALE:
                begin
                    if (is_locale_char(data_byte))
                    begin
                        step.role          = ROLE_LOCALE;
                        step.nonempty_next = 1'b1;
                    end
                    else if (data_byte == CH_RBRK && field_nonempty)
                    begin
                        step.role       = ROLE_DELIM;
                        step.phase_next = PH_LOCALE_END;
                    end
                    else
                        step.error_code = ERR_LOCALE;
                end
                PH_LOCALE_END:
                begin
                    if (data_byte == CH_EQ)
                    begin
                        step.role       = ROLE_DELIM;
                        step.phase_next = PH_VALUE_LOC;
                    end
                    else
                        step.error_code = ERR_LOCALE;
                end
                PH_VALUE, PH_VALUE_LOC:
                begin
                    if (nl)
                    begin
                        step.role       = ROLE_EOL;
                        step.line_event = EV_ASSIGN;
                        step.has_locale = (phase == PH_VALUE_LOC);
                    end
                    else
                        step.role = ROLE_VALUE;
                end
                default:
                    step.error_code = ERR_NOT_ASSIGN;
            endcase

            // Close an unterminated final line as a newline would
            if (step.error_code == ERR_NONE && !nl && last_byte)
            begin
                unique case (step.phase_next)
                    PH_GROUP:      step.error_code = ERR_GROUP;
                    PH_GROUP_END:  step.line_event = EV_GROUP;
                    PH_KEY:        step.error_code = ERR_NOT_ASSIGN;
                    PH_LOCALE,
                    PH_LOCALE_END: step.error_code = ERR_LOCALE;
                    PH_VALUE:      step.line_event = EV_ASSIGN;
                    PH_VALUE_LOC:
                    begin
                        step.line_event = EV_ASSIGN;
                        step.has_locale = 1'b1;
                    end
                    default: ;
                endcase
            end

            if (step.error_code != ERR_NONE)
            begin
                step.role       = ROLE_SKIP;
                step.line_event = EV_NONE;
                step.has_locale = 1'b0;
                step.phase_next = PH_HALT;
            end
            else
            begin
                step.item_inc = (step.line_event == EV_ASSIGN);
                step.line_inc = nl;
                if (nl)
                begin
                    step.phase_next    = PH_START;
                    step.nonempty_next = 1'b0;
                end
            end
        end
    end

endmodule

### hdl/keyfile_line_syntax_parser_top.sv
// Key file line checker: takes one file byte per request on req and returns one
// classified result per byte on res (role, line event, locale flag, error code,
// line number, item index, end-of-file flag). Throughput is one byte per clock
// while res takes results: each byte passes through combinational phase logic
// into the result register, so its result is on res in the cycle after it is
// taken; a new request is taken whenever the result register is empty or drains
// in the same cycle. The first syntax error halts parsing until the byte marked
// last_byte; after that byte all state returns to its reset values for the next
// file. Line and item counters are COUNT_WIDTH bits and saturate (low 16 bits on res).
module keyfile_line_syntax_parser_top #(
    parameter int COUNT_WIDTH = kls_pkg::COUNT_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    kls_req_if.sink   req,
    kls_res_if.source res
);
    import kls_pkg::*;

    phase_t                 phase_reg;
    logic                   nonempty_reg;
    logic [COUNT_WIDTH-1:0] line_reg;
    logic [COUNT_WIDTH-1:0] item_reg;

    logic                   out_valid_reg;
    logic [2:0]             role_reg;
    logic [1:0]             event_reg;
    logic                   locale_reg;
    logic [1:0]             error_reg;
    logic [15:0]            line_out_reg;
    logic [15:0]            item_out_reg;
    logic                   done_reg;

    logic                   accept;
    step_t                  step;
    logic [31:0]            line_wide;
    logic [31:0]            item_wide;
    logic [COUNT_WIDTH-1:0] line_next;
    logic [COUNT_WIDTH-1:0] item_next;

    // Take a request when the result slot is free or drains this cycle
    assign req.ready = !out_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    kls_step u_step (
        .phase          (phase_reg),
        .field_nonempty (nonempty_reg),
        .data_byte      (req.data_byte),
        .last_byte      (req.last_byte),
        .step           (step)
    );

    // Saturating counter advance
    assign line_next = (step.line_inc && line_reg != '1) ? line_reg + 1'b1 : line_reg;
    assign item_next = (step.item_inc && item_reg != '1) ? item_reg + 1'b1 : item_reg;

    // Widen before slicing so any COUNT_WIDTH in range maps onto 16 output bits
    assign line_wide = 32'(line_reg);
    assign item_wide = 32'(item_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            nonempty_reg  <= 1'b0;
            line_reg      <= COUNT_WIDTH'(1);
            item_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                // End of file: return to reset values for the next file
                if (req.last_byte)
                begin
                    phase_reg    <= PH_START;
                    nonempty_reg <= 1'b0;
                    line_reg     <= COUNT_WIDTH'(1);
                    item_reg     <= '0;
                end
                else
                begin
                    phase_reg    <= step.phase_next;
                    nonempty_reg <= step.nonempty_next;
                    line_reg     <= line_next;
                    item_reg     <= item_next;
                end
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            role_reg     <= step.role;
            event_reg    <= step.line_event;
            locale_reg   <= step.has_locale;
            error_reg    <= step.error_code;
            line_out_reg <= line_wide[OUT_COUNT_W-1:0];
            item_out_reg <= item_wide[OUT_COUNT_W-1:0];
            done_reg     <= req.last_byte;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.byte_role   = role_reg;
    assign res.line_event  = event_reg;
    assign res.has_locale  = locale_reg;
    assign res.error_code  = error_reg;
    assign res.line_number = line_out_reg;
    assign res.item_index  = item_out_reg;
    assign res.file_done   = done_reg;

endmodule
